/* design/cs2px_pkg.sv */
`default_nettype none

package cs2px_pkg;

  // Parameter defaults
  localparam int unsigned MAX_PREC_DEF   = 16;
  localparam int unsigned COEF_FRAC_DEF  = 16;

  // Fixed field widths
  localparam int unsigned SAMPLE_W   = 17;
  localparam int unsigned CHAN_W     = 16;
  localparam int unsigned BPC8       = 8;
  localparam int unsigned PREC_W     = 5;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 5;
  localparam int unsigned IN_DATA_W  = 56;
  localparam int unsigned OUT_DATA_W = 64;
  localparam int unsigned NUM_STG    = 5;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_COLOR_MODE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_FORMAT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PREC_0      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PREC_1      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PREC_2      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SIGNED_MASK = 3'd5;

  // Color modes (mode three converts like YCbCr)
  localparam logic [1:0] MODE_GRAY = 2'd0;
  localparam logic [1:0] MODE_RGB  = 2'd1;
  localparam logic [1:0] MODE_YCC  = 2'd2;

  // Output formats
  localparam logic FMT_BGRA8  = 1'b0;
  localparam logic FMT_RGBA16 = 1'b1;

  // Per-component scaler setup
  typedef struct packed {
    logic [PREC_W-1:0] prec;
    logic              sgnd;
    logic              fmt16;
  } comp_cfg_t;

  // Color converter setup
  typedef struct packed {
    logic [1:0] color_mode;
    logic       fmt16;
  } csc_cfg_t;

endpackage

`default_nettype wire

/* design/cs2px_scale.sv */
`default_nettype none

// Offset, clamp and rescale of one component: floor(v * outmax / (2^p - 1)).
// Three stages: range/prescale, reciprocal multiply, remainder correction.
module cs2px_scale
  import cs2px_pkg::*;
#(
  parameter int unsigned MAX_PREC = MAX_PREC_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       en,
  input  wire comp_cfg_t                  cfg,
  input  wire logic signed [SAMPLE_W-1:0] sample,
  output logic             [CHAN_W-1:0]   chan
);

  localparam int unsigned XW  = MAX_PREC + CHAN_W;
  localparam int unsigned PIW = $clog2(MAX_PREC + 1);

  logic [PIW-1:0] p;
  logic [XW-1:0]  dmax;

  // Effective precision, 1 .. MAX_PREC
  always_comb begin
    if (cfg.prec == '0) begin
      p = PIW'(1);
    end else if (cfg.prec > PREC_W'(MAX_PREC)) begin
      p = PIW'(MAX_PREC);
    end else begin
      p = cfg.prec[PIW-1:0];
    end
  end

  assign dmax = (XW'(1) << p) - XW'(1);

  // Reciprocal table: floor(2^XW / (2^p - 1)); precision one is handled apart
  logic [XW-1:0] recip_tab [MAX_PREC+1];

  genvar gp;
  generate
    for (gp = 0; gp <= MAX_PREC; gp++) begin : g_recip
      if (gp < 2) begin : g_none
        assign recip_tab[gp] = '0;
      end else begin : g_val
        localparam logic [XW-1:0] RC = XW'((64'd1 << XW) / ((64'd1 << gp) - 64'd1));
        assign recip_tab[gp] = RC;
      end
    end
  endgenerate

  // Stage 1: offset, clamp, x = v * outmax as shift and subtract
  logic signed [SAMPLE_W:0] sx;
  logic signed [SAMPLE_W:0] half;
  logic signed [SAMPLE_W:0] ssum;
  logic [MAX_PREC-1:0]      v;
  logic [XW-1:0]            x_nxt;
  logic [XW-1:0]            x_s1_r;
  logic [XW-1:0]            recip_s1_r;

  always_comb begin
    sx   = {sample[SAMPLE_W-1], sample};
    half = cfg.sgnd ? ((SAMPLE_W+1)'(1) << (p - PIW'(1))) : '0;
    ssum = sx + half;
    if (ssum[SAMPLE_W]) begin
      v = '0;
    end else if (XW'(ssum[SAMPLE_W-1:0]) > dmax) begin
      v = dmax[MAX_PREC-1:0];
    end else begin
      v = ssum[MAX_PREC-1:0];
    end
    if (cfg.fmt16) begin
      x_nxt = (XW'(v) << CHAN_W) - XW'(v);
    end else begin
      x_nxt = (XW'(v) << BPC8) - XW'(v);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_s1_r     <= x_nxt;
      recip_s1_r <= recip_tab[p];
    end
  end

  // Stage 2: quotient estimate, low by at most one
  logic [2*XW-1:0]   prod;
  logic [CHAN_W-1:0] qe_s2_r;
  logic [XW-1:0]     x_s2_r;

  assign prod = x_s1_r * recip_s1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      qe_s2_r <= prod[XW +: CHAN_W];
      x_s2_r  <= x_s1_r;
    end
  end

  // Stage 3: remainder check and final quotient
  logic [XW-1:0]     qd;
  logic [XW-1:0]     rem;
  logic [CHAN_W-1:0] chan_nxt;
  logic [CHAN_W-1:0] chan_r;

  always_comb begin
    qd  = (XW'(qe_s2_r) << p) - XW'(qe_s2_r);
    rem = x_s2_r - qd;
    if (p == PIW'(1)) begin
      chan_nxt = x_s2_r[CHAN_W-1:0];
    end else if (rem >= dmax) begin
      chan_nxt = qe_s2_r + CHAN_W'(1);
    end else begin
      chan_nxt = qe_s2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      chan_r <= chan_nxt;
    end
  end

  assign chan = chan_r;

endmodule

`default_nettype wire

/* design/cs2px_csc.sv */
`default_nettype none

// Color selection, fixed-point YCbCr to RGB and pixel packing.
// Stage 4: chroma centering and coefficient products. Stage 5: sums, clamp, pack.
module cs2px_csc
  import cs2px_pkg::*;
#(
  parameter int unsigned COEF_FRAC_BITS = COEF_FRAC_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  en,
  input  wire csc_cfg_t              cfg,
  input  wire logic [CHAN_W-1:0]     c0,
  input  wire logic [CHAN_W-1:0]     c1,
  input  wire logic [CHAN_W-1:0]     c2,
  output logic      [OUT_DATA_W-1:0] pixel_word
);

  localparam int unsigned F  = COEF_FRAC_BITS;
  localparam int unsigned CW = F + 2;
  localparam int unsigned DW = CHAN_W + 1;
  localparam int unsigned PW = CW + DW;
  localparam int unsigned NW = F + CHAN_W + 3;

  // Q(F) coefficients, rounded to nearest
  localparam logic signed [CW-1:0] K_CR_R =
    CW'(((64'd1402000 << F) + 64'd500000) / 64'd1000000);
  localparam logic signed [CW-1:0] K_CB_G =
    CW'(((64'd344136 << F) + 64'd500000) / 64'd1000000);
  localparam logic signed [CW-1:0] K_CR_G =
    CW'(((64'd714136 << F) + 64'd500000) / 64'd1000000);
  localparam logic signed [CW-1:0] K_CB_B =
    CW'(((64'd1772000 << F) + 64'd500000) / 64'd1000000);

  // Stage 4: center chroma and multiply
  logic signed [DW-1:0] kofs;
  logic signed [DW-1:0] cb;
  logic signed [DW-1:0] cr;
  logic signed [PW-1:0] p_r_nxt;
  logic signed [PW-1:0] p_gb_nxt;
  logic signed [PW-1:0] p_gr_nxt;
  logic signed [PW-1:0] p_b_nxt;
  logic signed [PW-1:0] p_r_r;
  logic signed [PW-1:0] p_gb_r;
  logic signed [PW-1:0] p_gr_r;
  logic signed [PW-1:0] p_b_r;
  logic [CHAN_W-1:0]    c0_s4_r;
  logic [CHAN_W-1:0]    c1_s4_r;
  logic [CHAN_W-1:0]    c2_s4_r;

  always_comb begin
    kofs     = cfg.fmt16 ? (DW'(1) << (CHAN_W - 1)) : (DW'(1) << (BPC8 - 1));
    cb       = $signed({1'b0, c1}) - kofs;
    cr       = $signed({1'b0, c2}) - kofs;
    p_r_nxt  = K_CR_R * cr;
    p_gb_nxt = K_CB_G * cb;
    p_gr_nxt = K_CR_G * cr;
    p_b_nxt  = K_CB_B * cb;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r_r   <= p_r_nxt;
      p_gb_r  <= p_gb_nxt;
      p_gr_r  <= p_gr_nxt;
      p_b_r   <= p_b_nxt;
      c0_s4_r <= c0;
      c1_s4_r <= c1;
      c2_s4_r <= c2;
    end
  end

  // Truncate toward zero and clamp to 0 .. outmax
  function automatic logic [CHAN_W-1:0] clamp_chan(input logic signed [NW-1:0] num,
                                                   input logic fmt16);
    logic signed [NW-1:0] t;
    logic [CHAN_W-1:0]    omax;
    t    = num >>> F;
    omax = fmt16 ? {CHAN_W{1'b1}} : CHAN_W'({BPC8{1'b1}});
    if (num < 0) begin
      clamp_chan = '0;
    end else if (t > $signed(NW'(omax))) begin
      clamp_chan = omax;
    end else begin
      clamp_chan = t[CHAN_W-1:0];
    end
  endfunction

  // Stage 5: channel sums, mode select, pack
  logic signed [NW-1:0]  yq;
  logic signed [NW-1:0]  num_r;
  logic signed [NW-1:0]  num_g;
  logic signed [NW-1:0]  num_b;
  logic [CHAN_W-1:0]     r;
  logic [CHAN_W-1:0]     g;
  logic [CHAN_W-1:0]     b;
  logic [OUT_DATA_W-1:0] pix_nxt;
  logic [OUT_DATA_W-1:0] pix_r;

  always_comb begin
    yq    = $signed(NW'(c0_s4_r)) <<< F;
    num_r = yq + NW'(p_r_r);
    num_g = yq - NW'(p_gb_r) - NW'(p_gr_r);
    num_b = yq + NW'(p_b_r);
    case (cfg.color_mode)
      MODE_GRAY: begin
        r = c0_s4_r;
        g = c0_s4_r;
        b = c0_s4_r;
      end
      MODE_RGB: begin
        r = c0_s4_r;
        g = c1_s4_r;
        b = c2_s4_r;
      end
      default: begin
        r = clamp_chan(num_r, cfg.fmt16);
        g = clamp_chan(num_g, cfg.fmt16);
        b = clamp_chan(num_b, cfg.fmt16);
      end
    endcase
    if (cfg.fmt16 == FMT_RGBA16) begin
      pix_nxt = {{CHAN_W{1'b1}}, b, g, r};
    end else begin
      pix_nxt = {32'h0, {BPC8{1'b1}}, r[BPC8-1:0], g[BPC8-1:0], b[BPC8-1:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pix_r <= pix_nxt;
    end
  end

  assign pixel_word = pix_r;

endmodule

`default_nettype wire

/* design/component_samples_to_rgb_pixel_core.sv */
`default_nettype none

// Channel  | Direction | Content
// ---------+-----------+-----------------------------------------------------
// in_      | slave     | three raw samples of one pixel
// out_     | master    | packed pixel word, opaque alpha
// cfg_     | write     | color_mode, out_format, prec_0..2, signed_mask
//
// One pixel per clock sustained while out_tready does not stall; the path has five register stages.
// The longest stage is the XW-by-XW reciprocal multiply in each scaler.
// A stall on out_tready freezes every stage together; nothing is lost or repeated.
// Synchronous reset clears the stage valid bits and loads register defaults.
// The user must write registers only with no transaction in flight; not enforced.
module component_samples_to_rgb_pixel_core
  import cs2px_pkg::*;
#(
  parameter int unsigned MAX_PREC       = MAX_PREC_DEF,
  parameter int unsigned COEF_FRAC_BITS = COEF_FRAC_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // in_tdata: sample_0[16:0], sample_1[33:17], sample_2[50:34], zero pad
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  // out_tdata: pixel_word[63:0]
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic      [OUT_DATA_W-1:0] out_tdata,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  // Configuration registers
  logic [1:0]        color_mode_r;
  logic              out_format_r;
  logic [PREC_W-1:0] prec_0_r;
  logic [PREC_W-1:0] prec_1_r;
  logic [PREC_W-1:0] prec_2_r;
  logic [2:0]        signed_mask_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_mode_r  <= MODE_RGB;
      out_format_r  <= FMT_BGRA8;
      prec_0_r      <= PREC_W'(8);
      prec_1_r      <= PREC_W'(8);
      prec_2_r      <= PREC_W'(8);
      signed_mask_r <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_COLOR_MODE:  color_mode_r  <= cfg_wdata[1:0];
        CFG_OUT_FORMAT:  out_format_r  <= cfg_wdata[0];
        CFG_PREC_0:      prec_0_r      <= cfg_wdata;
        CFG_PREC_1:      prec_1_r      <= cfg_wdata;
        CFG_PREC_2:      prec_2_r      <= cfg_wdata;
        CFG_SIGNED_MASK: signed_mask_r <= cfg_wdata[2:0];
        default: ;
      endcase
    end
  end

  // Pipeline advance and valid chain
  logic               en;
  logic [NUM_STG-1:0] valid_r;
  logic [NUM_STG-1:0] valid_nxt;

  assign en        = !valid_r[NUM_STG-1] || out_tready;
  assign in_tready = en;
  assign valid_nxt = {valid_r[NUM_STG-2:0], in_tvalid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (en) begin
      valid_r <= valid_nxt;
    end
  end

  // Component scalers
  comp_cfg_t         cc0, cc1, cc2;
  logic [CHAN_W-1:0] ch0, ch1, ch2;

  assign cc0 = '{prec: prec_0_r, sgnd: signed_mask_r[0], fmt16: out_format_r};
  assign cc1 = '{prec: prec_1_r, sgnd: signed_mask_r[1], fmt16: out_format_r};
  assign cc2 = '{prec: prec_2_r, sgnd: signed_mask_r[2], fmt16: out_format_r};

  cs2px_scale #(.MAX_PREC(MAX_PREC)) u_scale_0 (
    .clk    (clk),
    .en     (en),
    .cfg    (cc0),
    .sample (in_tdata[SAMPLE_W-1:0]),
    .chan   (ch0)
  );

  cs2px_scale #(.MAX_PREC(MAX_PREC)) u_scale_1 (
    .clk    (clk),
    .en     (en),
    .cfg    (cc1),
    .sample (in_tdata[2*SAMPLE_W-1:SAMPLE_W]),
    .chan   (ch1)
  );

  cs2px_scale #(.MAX_PREC(MAX_PREC)) u_scale_2 (
    .clk    (clk),
    .en     (en),
    .cfg    (cc2),
    .sample (in_tdata[3*SAMPLE_W-1:2*SAMPLE_W]),
    .chan   (ch2)
  );

  // Color conversion and packing
  csc_cfg_t csc_cfg;

  assign csc_cfg = '{color_mode: color_mode_r, fmt16: out_format_r};

  cs2px_csc #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_csc (
    .clk        (clk),
    .en         (en),
    .cfg        (csc_cfg),
    .c0         (ch0),
    .c1         (ch1),
    .c2         (ch2),
    .pixel_word (out_tdata)
  );

  assign out_tvalid = valid_r[NUM_STG-1];

  // Checks
  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> valid_r[0])
    else $error("accepted transaction did not enter the first stage");

  a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> $stable(valid_r))
    else $error("pipeline moved during an output stall");

  a_fmt8_layout: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_format_r == FMT_BGRA8)) |->
      (out_tdata[63:32] == 32'h0 && out_tdata[31:24] == 8'hFF))
    else $error("eight-bit pixel word badly packed");

  a_fmt16_alpha: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_format_r == FMT_RGBA16)) |-> (out_tdata[63:48] == 16'hFFFF))
    else $error("sixteen-bit pixel word lacks opaque alpha");

  a_prec_write: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_we && cfg_addr == CFG_PREC_0) |=> (prec_0_r == $past(cfg_wdata)))
    else $error("precision register write lost");

endmodule

`default_nettype wire

/* tb/tb_component_samples_to_rgb_pixel_core.sv */
`timescale 1ns / 100ps

module tb_component_samples_to_rgb_pixel_core;
  import cs2px_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_CYCLES  = 80;
  localparam int RAND_PHASES  = 12;
  localparam int PHASE_PIXELS = 100;

  // Indexes past the last register; writes there must change nothing
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_7 = 3'd7;

  // BT.601 full-range coefficients in millionths
  localparam longint CR_TO_R_MICRO = 1402000;
  localparam longint CB_TO_G_MICRO = 344136;
  localparam longint CR_TO_G_MICRO = 714136;
  localparam longint CB_TO_B_MICRO = 1772000;

  // Pixel converter predictor and queue of pending pixel words
  class pixel_scoreboard;
    logic [1:0]            color_mode;
    logic                  fmt16;
    logic [PREC_W-1:0]     prec [3];
    logic [2:0]            signed_mask;
    logic [OUT_DATA_W-1:0] pixel_q [$];
    int unsigned           errors;
    int unsigned           accepted;
    int unsigned           mode_cnt [4];
    int unsigned           fmt_cnt [2];

    function new();
      errors   = 0;
      accepted = 0;
      mode_cnt = '{0, 0, 0, 0};
      fmt_cnt  = '{0, 0};
      reset_regs();
    endfunction

    static function int unsigned eff_prec(logic [PREC_W-1:0] p);
      if (p == 0) return 1;
      if (p > MAX_PREC_DEF) return MAX_PREC_DEF;
      return p;
    endfunction

    static function longint coef_q(longint micro);
      return ((micro << COEF_FRAC_DEF) + 500000) / 1000000;
    endfunction

    function void reset_regs();
      color_mode  = MODE_RGB;
      fmt16       = FMT_BGRA8;
      prec        = '{5'd8, 5'd8, 5'd8};
      signed_mask = 3'd0;
    endfunction

    // mirror of the write port
    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_COLOR_MODE:  color_mode  = val[1:0];
        CFG_OUT_FORMAT:  fmt16       = val[0];
        CFG_PREC_0:      prec[0]     = val;
        CFG_PREC_1:      prec[1]     = val;
        CFG_PREC_2:      prec[2]     = val;
        CFG_SIGNED_MASK: signed_mask = val[2:0];
        default: ;
      endcase
    endfunction

    // offset, clamp to precision range, rescale to 0..outmax
    function longint rescale(logic [SAMPLE_W-1:0] raw, int comp, longint outmax);
      int unsigned p;
      longint      v;
      longint      maxv;
      p    = eff_prec(prec[comp]);
      maxv = (longint'(1) << p) - 1;
      v    = longint'($signed(raw));
      if (signed_mask[comp]) v += longint'(1) << (p - 1);
      if (v > maxv) v = maxv;
      if (v < 0) v = 0;
      return (v * outmax) / maxv;
    endfunction

    // drop fraction toward zero, then clamp
    function longint chan_limit(longint num, longint outmax);
      longint v;
      v = num / (longint'(1) << COEF_FRAC_DEF);
      if (v < 0) v = 0;
      if (v > outmax) v = outmax;
      return v;
    endfunction

    function void note_input(logic [IN_DATA_W-1:0] d);
      longint                outmax;
      longint                c0, c1, c2;
      longint                r, g, b;
      longint                k, yq, cb, cr;
      logic [OUT_DATA_W-1:0] px;
      outmax = fmt16 ? 65535 : 255;
      c0 = rescale(d[SAMPLE_W-1:0], 0, outmax);
      c1 = rescale(d[2*SAMPLE_W-1:SAMPLE_W], 1, outmax);
      c2 = rescale(d[3*SAMPLE_W-1:2*SAMPLE_W], 2, outmax);
      if (color_mode == MODE_GRAY) begin
        r = c0;
        g = c0;
        b = c0;
      end else if (color_mode[1]) begin
        // mode three converts as well
        k  = (outmax + 1) / 2;
        yq = c0 << COEF_FRAC_DEF;
        cb = c1 - k;
        cr = c2 - k;
        r  = chan_limit(yq + coef_q(CR_TO_R_MICRO) * cr, outmax);
        g  = chan_limit(yq - coef_q(CB_TO_G_MICRO) * cb - coef_q(CR_TO_G_MICRO) * cr, outmax);
        b  = chan_limit(yq + coef_q(CB_TO_B_MICRO) * cb, outmax);
      end else begin
        r = c0;
        g = c1;
        b = c2;
      end
      if (fmt16) px = {16'hFFFF, b[15:0], g[15:0], r[15:0]};
      else       px = {32'd0, 8'hFF, r[7:0], g[7:0], b[7:0]};
      pixel_q.push_back(px);
      accepted++;
      mode_cnt[color_mode]++;
      fmt_cnt[fmt16]++;
    endfunction

    function void check_result(logic [OUT_DATA_W-1:0] d);
      logic [OUT_DATA_W-1:0] want;
      if (pixel_q.size() == 0) begin
        $error("pixel_word: expected none, actual %h", d);
        errors++;
      end else begin
        want = pixel_q.pop_front();
        if (d !== want) begin
          $error("pixel_word mismatch: expected %h, actual %h", want, d);
          errors++;
        end
      end
    endfunction

    function int pending();
      return pixel_q.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n     = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata  = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_addr  = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  pixel_scoreboard sb = new();

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_left      = 0;
  logic        pressure_req   = 1'b0;
  logic        pressure_ack   = 1'b0;
  int unsigned cycle_count    = 0;
  int unsigned n_settings     = 0;

  component_samples_to_rgb_pixel_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Receiver: random stalls plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (pressure_req != pressure_ack) begin
      out_tready   <= 1'b0;
      pressure_ack <= pressure_req;
      hold_left    <= HOLD_CYCLES;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor: register writes, input and output transactions
  always @(posedge clk) begin
    if (rst_n && cfg_we) sb.write_reg(cfg_addr, cfg_wdata);
    if (rst_n && in_tvalid && in_tready) sb.note_input(in_tdata);
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  function automatic logic [IN_DATA_W-1:0] pack_samples(int s0, int s1, int s2);
    logic [IN_DATA_W-1:0] d;
    d = '0;
    d[SAMPLE_W-1:0]            = SAMPLE_W'(s0);
    d[2*SAMPLE_W-1:SAMPLE_W]   = SAMPLE_W'(s1);
    d[3*SAMPLE_W-1:2*SAMPLE_W] = SAMPLE_W'(s2);
    return d;
  endfunction

  // Mostly in-range values for the component's precision, some edges, some raw noise
  function automatic int random_sample(int comp);
    int unsigned p;
    int          span;
    int          lo;
    p    = pixel_scoreboard::eff_prec(sb.prec[comp]);
    span = 1 << p;
    lo   = sb.signed_mask[comp] ? -(span / 2) : 0;
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: return lo + int'($urandom_range(span - 1));
      6: begin
        case ($urandom_range(4))
          0: return lo;
          1: return lo + span - 1;
          2: return lo - 1;
          3: return lo + span;
          default: return 0;
        endcase
      end
      default: return int'($urandom_range(17'h1FFFF));
    endcase
  endfunction

  function automatic logic [PREC_W-1:0] random_prec();
    if ($urandom_range(3) == 0) return PREC_W'($urandom_range(31));
    return PREC_W'($urandom_range(MAX_PREC_DEF, 1));
  endfunction

  task automatic send_pixel(input logic [IN_DATA_W-1:0] d);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    do @(posedge clk); while (!in_tready);
  endtask

  // Drain: every pixel back, then let the pipeline settle
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (NUM_STG + 2) @(posedge clk);
  endtask

  // Write all registers back to back; noisy sets unused upper bits and hits spare indexes
  task automatic load_setting(input logic [1:0] mode, input logic fmt,
                              input logic [PREC_W-1:0] p0, input logic [PREC_W-1:0] p1,
                              input logic [PREC_W-1:0] p2, input logic [2:0] mask,
                              input bit noisy);
    logic [CFG_DATA_W-1:0] pad;
    pad = noisy ? CFG_DATA_W'($urandom) : '0;
    cfg_we    <= 1'b1;
    cfg_addr  <= CFG_COLOR_MODE;
    cfg_wdata <= {pad[4:2], mode};
    @(posedge clk);
    cfg_addr  <= CFG_OUT_FORMAT;
    cfg_wdata <= {pad[4:1], fmt};
    @(posedge clk);
    cfg_addr  <= CFG_PREC_0;
    cfg_wdata <= p0;
    @(posedge clk);
    cfg_addr  <= CFG_PREC_1;
    cfg_wdata <= p1;
    @(posedge clk);
    cfg_addr  <= CFG_PREC_2;
    cfg_wdata <= p2;
    @(posedge clk);
    cfg_addr  <= CFG_SIGNED_MASK;
    cfg_wdata <= {pad[4:3], mask};
    @(posedge clk);
    if (noisy) begin
      cfg_addr  <= CFG_SPARE_6;
      cfg_wdata <= CFG_DATA_W'($urandom);
      @(posedge clk);
      cfg_addr  <= CFG_SPARE_7;
      cfg_wdata <= CFG_DATA_W'($urandom);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
    n_settings++;
  endtask

  initial begin
    int ph;
    rst_n <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset defaults: RGB pass-through, 8-bit unsigned, BGRA8
    send_pixel(pack_samples(0, 0, 0));
    send_pixel(pack_samples(255, 255, 255));
    send_pixel(pack_samples(-65536, 65535, -1));
    send_pixel(pack_samples(128, 64, 300));
    wait_idle();

    // YCbCr, 8-bit: neutral black/white, clipping of each channel
    load_setting(MODE_YCC, FMT_BGRA8, 5'd8, 5'd8, 5'd8, 3'd0, 1'b0);
    send_pixel(pack_samples(0, 128, 128));
    send_pixel(pack_samples(255, 128, 128));
    send_pixel(pack_samples(0, 0, 255));
    send_pixel(pack_samples(255, 255, 0));
    send_pixel(pack_samples(76, 85, 255));
    wait_idle();

    // YCbCr, 16-bit, signed chroma
    load_setting(MODE_YCC, FMT_RGBA16, 5'd16, 5'd16, 5'd16, 3'd6, 1'b0);
    send_pixel(pack_samples(65535, 0, 0));
    send_pixel(pack_samples(0, -32768, 32767));
    send_pixel(pack_samples(65535, 32767, -32768));
    send_pixel(pack_samples(-65536, 65535, 0));
    wait_idle();

    // Mode three, precision zero and above the maximum, all signed
    load_setting(2'd3, FMT_RGBA16, 5'd0, 5'd17, 5'd31, 3'd7, 1'b1);
    send_pixel(pack_samples(0, 0, 0));
    send_pixel(pack_samples(1, -1, 65535));
    send_pixel(pack_samples(-1, -65536, 32767));
    wait_idle();

    // Gray from signed 12-bit component 0
    load_setting(MODE_GRAY, FMT_BGRA8, 5'd12, 5'd1, 5'd1, 3'd1, 1'b1);
    send_pixel(pack_samples(2047, 5, 5));
    send_pixel(pack_samples(-2048, 0, 0));
    send_pixel(pack_samples(65535, -1, -1));
    send_pixel(pack_samples(-65536, 0, 0));
    wait_idle();

    // Gray, 1-bit precision, 16-bit output
    load_setting(MODE_GRAY, FMT_RGBA16, 5'd1, 5'd16, 5'd16, 3'd0, 1'b0);
    send_pixel(pack_samples(1, 0, 0));
    send_pixel(pack_samples(0, 1, 1));
    send_pixel(pack_samples(2, 0, 0));
    wait_idle();

    // Random phases, each with its own setting and idling pattern
    for (ph = 0; ph < RAND_PHASES; ph++) begin
      load_setting(2'($urandom_range(3)), 1'($urandom_range(1)), random_prec(),
                   random_prec(), random_prec(), 3'($urandom_range(7)),
                   bit'($urandom_range(1)));
      case (ph % 4)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct <= 0;
        end
        1: begin
          send_idle_pct  = 50;
          recv_stall_pct <= 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct <= 50;
        end
        default: begin
          send_idle_pct  = 12;
          recv_stall_pct <= 12;
        end
      endcase
      // long receiver hold-off while pixels keep coming
      if (ph % 8 == 0) pressure_req <= ~pressure_req;
      repeat (PHASE_PIXELS) begin
        send_pixel(pack_samples(random_sample(0), random_sample(1), random_sample(2)));
      end
      wait_idle();
    end

    repeat (4 * NUM_STG) @(posedge clk);
    $display("Converted %0d pixels under %0d register settings (gray %0d, rgb %0d, ycbcr %0d).",
             sb.accepted, n_settings, sb.mode_cnt[0], sb.mode_cnt[1],
             sb.mode_cnt[2] + sb.mode_cnt[3]);
    $display("Output words: %0d in BGRA8, %0d in RGBA16; %0d errors.",
             sb.fmt_cnt[0], sb.fmt_cnt[1], sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
